// File: rtl/bcc_pkg.sv
`default_nettype none
package bcc_pkg;

	localparam int CFG_W          = 10;
	localparam int NUM_REGS       = 5;
	localparam int CFG_IDX_W      = 3;
	localparam int COUNT_BITS_DEF = 10;
	localparam int HIST_W         = 4;
	localparam int CLICK_W        = 2;
	localparam int PHASE_W        = 3;

	localparam logic             PRESSED_LEVEL_RST = 1'b0;
	localparam logic [CFG_W-1:0] CONFIRM_RST       = 10'd4;
	localparam logic [CFG_W-1:0] LONG_RST          = 10'd100;
	localparam logic [CFG_W-1:0] GAP_RST           = 10'd30;
	localparam logic [CFG_W-1:0] REPEAT_RST        = 10'd50;

	localparam logic [HIST_W-1:0] PRESS_PAT   = 4'b0011;
	localparam logic [HIST_W-1:0] RELEASE_PAT = 4'b1100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRESSED_LEVEL = 3'd0,
		REG_CONFIRM_TICKS = 3'd1,
		REG_LONG_TICKS    = 3'd2,
		REG_GAP_TICKS     = 3'd3,
		REG_REPEAT_TICKS  = 3'd4
	} reg_idx_t;

	typedef enum logic [CLICK_W-1:0] {
		CLICK_NONE   = 2'd0,
		CLICK_SINGLE = 2'd1,
		CLICK_DOUBLE = 2'd2,
		CLICK_REPEAT = 2'd3
	} click_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE     = 3'd0,
		PH_CONFIRM  = 3'd1,
		PH_LONGWAIT = 3'd2,
		PH_GAP      = 3'd3,
		PH_SINGLE   = 3'd4,
		PH_DOUBLE   = 3'd5,
		PH_HELD     = 3'd6
	} phase_t;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_CONFIRM  = 7'b0000010,
		ST_LONGWAIT = 7'b0000100,
		ST_GAP      = 7'b0001000,
		ST_SINGLE   = 7'b0010000,
		ST_DOUBLE   = 7'b0100000,
		ST_HELD     = 7'b1000000
	} state_t;

	function automatic phase_t state_phase(state_t st);
		phase_t ph;
		case (st)
			ST_IDLE:     ph = PH_IDLE;
			ST_CONFIRM:  ph = PH_CONFIRM;
			ST_LONGWAIT: ph = PH_LONGWAIT;
			ST_GAP:      ph = PH_GAP;
			ST_SINGLE:   ph = PH_SINGLE;
			ST_DOUBLE:   ph = PH_DOUBLE;
			ST_HELD:     ph = PH_HELD;
			default:     ph = PH_IDLE;
		endcase
		return ph;
	endfunction

endpackage
`default_nettype wire

// File: rtl/bcc_if.sv
`default_nettype none
interface bcc_in_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink   (input valid, input pin_level, output ready);
endinterface

interface bcc_out_if;
	logic                         valid;
	logic                         ready;
	logic [bcc_pkg::CLICK_W-1:0]  click_event;
	logic [bcc_pkg::PHASE_W-1:0]  phase;

	modport source (output valid, output click_event, output phase, input ready);
	modport sink   (input valid, input click_event, input phase, output ready);
endinterface
`default_nettype wire

// File: rtl/button_click_classifier.sv
// Button click classifier: one pin sample per scan tick goes in on the sample channel and one
// result word (click event and phase after the tick) comes out on the result channel for every
// sample taken. The block takes one word per clock cycle unless the full output register is
// stalled; the result appears in the cycle after its sample, in that single register, which
// refills in the same cycle it is drained, so ready on the sample side follows the result side
// only while that register is full. Timing thresholds are to be written through the cfg port
// only while the block is idle, not enforced by the block; the tick counter is COUNT_BITS wide.
`default_nettype none
module button_click_classifier #(
	parameter int COUNT_BITS = bcc_pkg::COUNT_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bcc_pkg::CFG_W-1:0]      cfg_data,
	bcc_in_if.sink                              sample,
	bcc_out_if.source                           result
);

	localparam int CMP_W = (COUNT_BITS > bcc_pkg::CFG_W) ? COUNT_BITS : bcc_pkg::CFG_W;

	logic                        pressed_level_q;
	logic [bcc_pkg::CFG_W-1:0]   confirm_q, long_q, gap_q, repeat_q;

	logic [bcc_pkg::HIST_W-1:0]  hist_q, hist_d;
	bcc_pkg::state_t             state_q, state_d;
	logic [COUNT_BITS-1:0]       cnt_q, cnt_d, cnt_inc;

	logic                        out_valid_q;
	bcc_pkg::click_t             click_q, click_d;
	bcc_pkg::phase_t             phase_q;

	logic                        accept;
	logic                        press_edge, release_edge;
	logic [bcc_pkg::CFG_W-1:0]   limit, period;
	logic                        leave_edge;
	bcc_pkg::state_t             edge_next, timeout_next;

	assign sample.ready = !out_valid_q || result.ready;
	assign accept       = sample.valid && sample.ready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_level_q <= bcc_pkg::PRESSED_LEVEL_RST;
			confirm_q       <= bcc_pkg::CONFIRM_RST;
			long_q          <= bcc_pkg::LONG_RST;
			gap_q           <= bcc_pkg::GAP_RST;
			repeat_q        <= bcc_pkg::REPEAT_RST;
		end else if (cfg_we) begin
			case (bcc_pkg::reg_idx_t'(cfg_index))
				bcc_pkg::REG_PRESSED_LEVEL: pressed_level_q <= cfg_data[0];
				bcc_pkg::REG_CONFIRM_TICKS: confirm_q       <= cfg_data;
				bcc_pkg::REG_LONG_TICKS:    long_q          <= cfg_data;
				bcc_pkg::REG_GAP_TICKS:     gap_q           <= cfg_data;
				bcc_pkg::REG_REPEAT_TICKS:  repeat_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	assign hist_d       = {hist_q[bcc_pkg::HIST_W-2:0], sample.pin_level == pressed_level_q};
	assign press_edge   = hist_d == bcc_pkg::PRESS_PAT;
	assign release_edge = hist_d == bcc_pkg::RELEASE_PAT;
	assign cnt_inc      = cnt_q + 1'b1;
	assign period       = (repeat_q == '0) ? bcc_pkg::CFG_W'(1) : repeat_q;

	// wait-phase selection
	always_comb begin
		limit        = confirm_q;
		leave_edge   = release_edge;
		edge_next    = bcc_pkg::ST_GAP;
		timeout_next = bcc_pkg::ST_LONGWAIT;
		case (state_q)
			bcc_pkg::ST_LONGWAIT: begin
				limit        = long_q;
				timeout_next = bcc_pkg::ST_HELD;
			end
			bcc_pkg::ST_GAP: begin
				limit        = gap_q;
				leave_edge   = press_edge;
				edge_next    = bcc_pkg::ST_DOUBLE;
				timeout_next = bcc_pkg::ST_SINGLE;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		click_d = bcc_pkg::CLICK_NONE;
		case (state_q)
			bcc_pkg::ST_IDLE: begin
				if (press_edge) begin
					state_d = bcc_pkg::ST_CONFIRM;
					cnt_d   = '0;
				end
			end
			bcc_pkg::ST_CONFIRM, bcc_pkg::ST_LONGWAIT, bcc_pkg::ST_GAP: begin
				if (CMP_W'(cnt_q) < CMP_W'(limit)) begin
					if (leave_edge) begin
						state_d = edge_next;
						cnt_d   = '0;
					end else begin
						cnt_d = cnt_inc;
					end
				end else begin
					state_d = timeout_next;
					cnt_d   = '0;
				end
			end
			bcc_pkg::ST_SINGLE: begin
				click_d = bcc_pkg::CLICK_SINGLE;
				state_d = bcc_pkg::ST_IDLE;
			end
			bcc_pkg::ST_DOUBLE: begin
				click_d = bcc_pkg::CLICK_DOUBLE;
				state_d = bcc_pkg::ST_IDLE;
			end
			bcc_pkg::ST_HELD: begin
				if (release_edge) begin
					state_d = bcc_pkg::ST_IDLE;
					cnt_d   = '0;
				end else begin
					if (cnt_q == '0) begin
						click_d = bcc_pkg::CLICK_REPEAT;
					end
					if (CMP_W'(cnt_inc) >= CMP_W'(period)) begin
						cnt_d = '0;
					end else begin
						cnt_d = cnt_inc;
					end
				end
			end
			default: begin
				state_d = bcc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			state_q <= bcc_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else if (accept) begin
			hist_q  <= hist_d;
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sample.ready) begin
			out_valid_q <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			click_q <= click_d;
			phase_q <= bcc_pkg::state_phase(state_d);
		end
	end

	assign result.valid       = out_valid_q;
	assign result.click_event = click_q;
	assign result.phase       = phase_q;

	a_click_phase_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (click_q == bcc_pkg::CLICK_SINGLE || click_q == bcc_pkg::CLICK_DOUBLE)
		|-> phase_q == bcc_pkg::PH_IDLE)
		else $error("single or double click word not in idle phase");

	a_repeat_phase_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && click_q == bcc_pkg::CLICK_REPEAT |-> phase_q == bcc_pkg::PH_HELD)
		else $error("repeat click word not in held phase");

	a_single_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (state_q == bcc_pkg::ST_SINGLE || state_q == bcc_pkg::ST_DOUBLE)
		|=> state_q == bcc_pkg::ST_IDLE && click_q != bcc_pkg::CLICK_NONE)
		else $error("click state did not emit and return to idle");

endmodule
`default_nettype wire

// File: bench/bcc_checker.sv
`timescale 1ns / 1ps
module bcc_checker
	import bcc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	bcc_in_if                         sample,
	bcc_out_if                        result,
	output int unsigned               fails,
	output int unsigned               pending,
	output int unsigned               checked
);

	typedef struct packed {
		click_t click;
		phase_t ph;
	} tick_result_t;

	tick_result_t due_results[$];

	int unsigned fail_count = 0;
	int unsigned due_count = 0;
	int unsigned check_count = 0;

	logic                      lvl_q = PRESSED_LEVEL_RST;
	logic [CFG_W-1:0]          confirm_q = CONFIRM_RST;
	logic [CFG_W-1:0]          long_q = LONG_RST;
	logic [CFG_W-1:0]          gap_q = GAP_RST;
	logic [CFG_W-1:0]          repeat_q = REPEAT_RST;
	logic [HIST_W-1:0]         hist_q = '0;
	phase_t                    ph_q = PH_IDLE;
	logic [COUNT_BITS_DEF-1:0] cnt_q = '0;

	assign fails   = fail_count;
	assign pending = due_count;
	assign checked = check_count;

	// count up while waiting, leave early on the given edge, move on once the limit is reached
	function automatic void wait_or_leave(input logic [CFG_W-1:0] limit, input logic leave,
		input phase_t on_leave, input phase_t on_timeout);
		if (cnt_q < limit) begin
			if (leave) begin
				ph_q  = on_leave;
				cnt_q = '0;
			end else
				cnt_q = cnt_q + 1'b1;
		end else begin
			ph_q  = on_timeout;
			cnt_q = '0;
		end
	endfunction

	function automatic tick_result_t classify_tick(input logic pin);
		tick_result_t      res;
		logic              press_edge;
		logic              release_edge;
		logic [CFG_W-1:0]  period;
		hist_q       = {hist_q[HIST_W-2:0], pin == lvl_q};
		press_edge   = (hist_q == PRESS_PAT);
		release_edge = (hist_q == RELEASE_PAT);
		res.click    = CLICK_NONE;
		case (ph_q)
			PH_IDLE: begin
				if (press_edge) begin
					ph_q  = PH_CONFIRM;
					cnt_q = '0;
				end
			end
			PH_CONFIRM:  wait_or_leave(confirm_q, release_edge, PH_GAP, PH_LONGWAIT);
			PH_LONGWAIT: wait_or_leave(long_q, release_edge, PH_GAP, PH_HELD);
			PH_GAP:      wait_or_leave(gap_q, press_edge, PH_DOUBLE, PH_SINGLE);
			PH_SINGLE: begin
				res.click = CLICK_SINGLE;
				ph_q      = PH_IDLE;
			end
			PH_DOUBLE: begin
				res.click = CLICK_DOUBLE;
				ph_q      = PH_IDLE;
			end
			PH_HELD: begin
				if (release_edge) begin
					ph_q  = PH_IDLE;
					cnt_q = '0;
				end else begin
					period = (repeat_q == '0) ? CFG_W'(1) : repeat_q;
					if (cnt_q == '0)
						res.click = CLICK_REPEAT;
					cnt_q = cnt_q + 1'b1;
					if (cnt_q >= period)
						cnt_q = '0;
				end
			end
			default: ph_q = PH_IDLE;
		endcase
		res.ph = ph_q;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_result_t want;
		if (!arst_n) begin
			lvl_q     = PRESSED_LEVEL_RST;
			confirm_q = CONFIRM_RST;
			long_q    = LONG_RST;
			gap_q     = GAP_RST;
			repeat_q  = REPEAT_RST;
			hist_q    = '0;
			ph_q      = PH_IDLE;
			cnt_q     = '0;
			due_results.delete();
			due_count = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result word, click %0d phase %0d",
						$time, result.click_event, result.phase);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					check_count++;
					if (result.click_event !== want.click || result.phase !== want.ph) begin
						$display("%0t: mismatch, expected click %0d phase %0d, got click %0d phase %0d",
							$time, want.click, want.ph, result.click_event, result.phase);
						fail_count++;
					end
				end
			end
			if (sample.valid && sample.ready)
				due_results.push_back(classify_tick(sample.pin_level));
			if (cfg_we) begin
				case (cfg_index)
					REG_PRESSED_LEVEL: lvl_q = cfg_data[0];
					REG_CONFIRM_TICKS: confirm_q = cfg_data;
					REG_LONG_TICKS:    long_q = cfg_data;
					REG_GAP_TICKS:     gap_q = cfg_data;
					REG_REPEAT_TICKS:  repeat_q = cfg_data;
					default: ;
				endcase
			end
			due_count = due_results.size();
		end
	end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import bcc_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned SPAN_CAP = 40;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int unsigned fails;
	int unsigned due_count;
	int unsigned checked;

	int unsigned send_idle = 0;
	int unsigned recv_stall = 0;
	int unsigned words_sent = 0;
	int unsigned settings_run = 0;

	logic        cur_lvl = 1'b0;
	int unsigned cur_confirm = 0;
	int unsigned cur_long = 0;
	int unsigned cur_gap = 0;
	int unsigned cur_repeat = 0;

	bcc_in_if  sample_ch();
	bcc_out_if result_ch();

	button_click_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	bcc_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch),
		.fails     (fails),
		.pending   (due_count),
		.checked   (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("simulation failed");
		$finish;
	end

	function automatic int unsigned capped(input int unsigned v);
		return (v > SPAN_CAP) ? SPAN_CAP : v;
	endfunction

	task automatic send_word(input logic pin);
		while ($urandom_range(0, 99) < send_idle) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.pin_level <= pin;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		words_sent++;
		@(negedge clk);
	endtask

	// n ticks of pressed or released, in terms of the current polarity
	task automatic run_level(input bit pressed, input int unsigned n);
		repeat (n) send_word(pressed ? cur_lvl : !cur_lvl);
	endtask

	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		@(negedge clk);
		while (due_count != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
	endtask

	task automatic apply_setting(input logic lvl, input int unsigned c, input int unsigned l,
		input int unsigned g, input int unsigned r);
		drain_results();
		write_reg(REG_PRESSED_LEVEL, CFG_W'(lvl));
		write_reg(REG_CONFIRM_TICKS, CFG_W'(c));
		write_reg(REG_LONG_TICKS, CFG_W'(l));
		write_reg(REG_GAP_TICKS, CFG_W'(g));
		write_reg(REG_REPEAT_TICKS, CFG_W'(r));
		// unmapped indexes must be ignored
		for (int k = NUM_REGS; k < (1 << CFG_IDX_W); k++)
			write_reg(CFG_IDX_W'(k), CFG_W'($urandom));
		cfg_we      <= 1'b0;
		cur_lvl     = lvl;
		cur_confirm = c;
		cur_long    = l;
		cur_gap     = g;
		cur_repeat  = r;
		settings_run++;
	endtask

	task automatic small_setting();
		apply_setting(1'($urandom_range(0, 1)), $urandom_range(0, 6), $urandom_range(0, 8),
			$urandom_range(0, 8), $urandom_range(0, 5));
	endtask

	task automatic random_gesture();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			// single click
			run_level(1'b0, $urandom_range(2, 3));
			run_level(1'b1, 2 + $urandom_range(0, capped(cur_confirm)));
			run_level(1'b0, capped(cur_gap) + 3);
		end else if (pick < 55) begin
			// double click
			run_level(1'b0, 2);
			run_level(1'b1, 2 + $urandom_range(0, capped(cur_confirm)));
			run_level(1'b0, 2 + $urandom_range(0, capped(cur_gap)));
			run_level(1'b1, 2 + $urandom_range(0, 2));
			run_level(1'b0, capped(cur_gap) + 3);
		end else if (pick < 80) begin
			// long press with repeats
			run_level(1'b0, 2);
			run_level(1'b1, capped(cur_confirm + cur_long) + 4
				+ $urandom_range(0, capped(3 * cur_repeat + 3)));
			run_level(1'b0, 2 + $urandom_range(0, 2));
		end else begin
			repeat ($urandom_range(3, 10)) send_word(1'($urandom_range(0, 1)));
		end
	endtask

	task automatic random_phase(input int unsigned target);
		int unsigned first;
		bit          paused;
		first  = words_sent;
		paused = 1'b0;
		while (words_sent - first < target) begin
			if (!paused && words_sent - first >= target / 2) begin
				drain_results();
				paused = 1'b1;
			end
			random_gesture();
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;
		sample_ch.valid     = 1'b0;
		sample_ch.pin_level = 1'b0;
		result_ch.ready     = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: single, double, then a long press that reaches the held phase with zero repeat period
		apply_setting(1'b1, 2, 2, 3, 0);
		run_level(1'b0, 2);
		run_level(1'b1, 2);
		run_level(1'b0, 7);
		run_level(1'b1, 2);
		run_level(1'b0, 2);
		run_level(1'b1, 2);
		run_level(1'b0, 2);
		run_level(1'b1, 6);
		run_level(1'b0, 2);

		send_idle  = 0;
		recv_stall = 0;
		small_setting();
		random_phase(120);

		send_idle = 80;
		small_setting();
		random_phase(120);

		send_idle  = 0;
		recv_stall = 80;
		small_setting();
		random_phase(120);

		send_idle  = 12;
		recv_stall = 12;
		small_setting();
		random_phase(120);

		// zero thresholds
		apply_setting(1'b0, 0, 0, 0, 0);
		random_phase(25);

		send_idle  = 0;
		recv_stall = 0;
		apply_setting(1'($urandom_range(0, 1)), 1023, 1023, 1023, 1023);
		random_phase(30);

		drain_results();
		repeat (8) @(posedge clk);
		$display("%0d sample words over %0d register settings and four idling mixes",
			words_sent, settings_run);
		$display("%0d result words checked, %0d failures", checked, fails);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/bcc_pkg.sv
rtl/bcc_if.sv
rtl/button_click_classifier.sv
bench/bcc_checker.sv
bench/tb_top.sv
